@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL of the ordered list block; the engine includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define OLAD_ASSERT_NOW(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// Condition holds in the cycle after the trigger.
`define OLAD_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

@@ rtl/olad_pkg.sv @@
// Package with the types, sizes and codes of the ordered list block.
`default_nettype none

package olad_pkg;

  // Number of list entries and the widths that follow from it.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Request kinds; the last code is unused and gives no result.
  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_LIST   = 2'd2;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_APPENDED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_LISTED    = 3'd5;

  // Request word.
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] item_value;
  } in_item_t;

  // Result word.
  typedef struct packed {
    logic signed [31:0] out_value;
    logic [2:0]         status;
    logic               last;
  } out_item_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic idle;
    logic res_valid;
  } eng_stat_t;

endpackage

`default_nettype wire

@@ rtl/olad_engine.sv @@
// Sequencer, entry memory and comparator that carry out list requests.
`default_nettype none

module olad_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire olad_pkg::in_item_t req,
  input  wire logic               res_ready,
  output olad_pkg::eng_stat_t     stat,
  output olad_pkg::out_item_t     res
);

  `include "assert_macros.svh"

  localparam int IDX_W = olad_pkg::IDX_W;
  localparam int CNT_W = olad_pkg::CNT_W;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_LGET  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]         state, state_next;
  logic [IDX_W-1:0]   idx, idx_next;
  logic [CNT_W-1:0]   count, count_next;
  logic signed [31:0] val, val_next;
  logic signed [31:0] res_value, res_value_next;
  logic [2:0]         res_status, res_status_next;
  logic               res_last, res_last_next;
  logic               listing, listing_next;

  // Entry memory with one write and one registered read port.
  localparam int CAPACITY_DEPTH = olad_pkg::CAPACITY;
  logic signed [31:0] mem [CAPACITY_DEPTH];
  logic signed [31:0] rd_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic               we;
  logic [IDX_W-1:0]   wa;
  logic signed [31:0] wd;

  logic [CNT_W-1:0]   idx_inc;

  assign idx_inc = CNT_W'(idx) + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Next-state logic: entries are read, compared or moved in turn.
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    val_next        = val;
    res_value_next  = res_value;
    res_status_next = res_status;
    res_last_next   = res_last;
    listing_next    = listing;
    rd_en           = 1'b0;
    rd_addr         = idx;
    we              = 1'b0;
    wa              = idx;
    wd              = val;
    case (state)
      S_IDLE: begin
        if (start) begin
          val_next       = req.item_value;
          res_value_next = req.item_value;
          res_last_next  = 1'b1;
          listing_next   = 1'b0;
          case (req.req_type)
            olad_pkg::REQ_APPEND: begin
              if (count == CNT_W'(olad_pkg::CAPACITY)) begin
                res_status_next = olad_pkg::ST_FULL;
              end else begin
                we              = 1'b1;
                wa              = IDX_W'(count);
                wd              = req.item_value;
                count_next      = count + CNT_W'(1);
                res_status_next = olad_pkg::ST_APPENDED;
              end
              state_next = S_EMIT;
            end
            olad_pkg::REQ_DELETE: begin
              if (count == '0) begin
                res_status_next = olad_pkg::ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                idx_next   = '0;
                state_next = S_SCAN;
              end
            end
            olad_pkg::REQ_LIST: begin
              if (count == '0) begin
                res_status_next = olad_pkg::ST_EMPTY;
                state_next      = S_EMIT;
              end else begin
                rd_en        = 1'b1;
                rd_addr      = '0;
                idx_next     = '0;
                listing_next = 1'b1;
                state_next   = S_LGET;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // rd_data holds entry idx; the next entry is fetched meanwhile.
        rd_en   = 1'b1;
        rd_addr = IDX_W'(idx_inc);
        if (rd_data == val) begin
          state_next = S_SHIFT;
        end else if (idx_inc == count) begin
          res_status_next = olad_pkg::ST_NOT_FOUND;
          state_next      = S_EMIT;
        end else begin
          idx_next = IDX_W'(idx_inc);
        end
      end
      S_SHIFT: begin
        // rd_data holds entry idx+1, which moves down into place idx.
        if (idx_inc < count) begin
          we       = 1'b1;
          wa       = idx;
          wd       = rd_data;
          rd_en    = 1'b1;
          rd_addr  = IDX_W'(idx_inc + CNT_W'(1));
          idx_next = IDX_W'(idx_inc);
        end else begin
          count_next      = count - CNT_W'(1);
          res_status_next = olad_pkg::ST_DELETED;
          state_next      = S_EMIT;
        end
      end
      S_LGET: begin
        res_value_next  = rd_data;
        res_status_next = olad_pkg::ST_LISTED;
        res_last_next   = (idx_inc == count);
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (res_ready) begin
          if (listing && !res_last) begin
            idx_next   = IDX_W'(idx_inc);
            rd_en      = 1'b1;
            rd_addr    = IDX_W'(idx_inc);
            state_next = S_LGET;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state is cleared by reset; the payload registers are not.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      listing <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      listing <= listing_next;
    end
    idx        <= idx_next;
    val        <= val_next;
    res_value  <= res_value_next;
    res_status <= res_status_next;
    res_last   <= res_last_next;
  end

  assign stat.idle      = (state == S_IDLE);
  assign stat.res_valid = (state == S_EMIT);
  assign res.out_value  = res_value;
  assign res.status     = res_status;
  assign res.last       = res_last;

  // Conditions watched by the assertions below.
  logic append_go;
  logic last_go;

  assign append_go = (state == S_IDLE) && start && (req.req_type == olad_pkg::REQ_APPEND)
                     && (count < CNT_W'(olad_pkg::CAPACITY));
  assign last_go   = (state == S_EMIT) && res_ready && res_last;

  `OLAD_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(olad_pkg::CAPACITY), "count above capacity")
  `OLAD_ASSERT_NEXT(a_append_grows, append_go, count == $past(count) + CNT_W'(1), "append lost")
  `OLAD_ASSERT_NEXT(a_last_ends, last_go, state == S_IDLE, "no idle after last word")

endmodule

`default_nettype wire

@@ rtl/ordered_list_append_delete_top.sv @@
// Top level of the ordered list block: request intake and result register.
//
//   channel  | direction | handshake                  | word
//   item     | in        | item_valid / item_ready    | olad_pkg::in_item_t
//   result   | out       | result_valid / result_ready | olad_pkg::out_item_t
//
// An append is done when taken, then emitted. A delete scans the entries in
// order; on a match it moves each later entry down one place and closes the
// move in a further step, then emits. A list reads and emits each entry in
// turn. The shared memory port and comparator serve one request at a time.
// Reset is synchronous and empties the list at once; no clearing pass.
// A stalled result register holds the sequencer in its emit step.
`default_nettype none

module ordered_list_append_delete_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_ready,
  input  wire olad_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output olad_pkg::out_item_t      result
);

  olad_pkg::eng_stat_t stat;
  olad_pkg::out_item_t res;
  logic                res_ready;
  logic                start;

  // A request is taken only while the sequencer is idle.
  assign item_ready = stat.idle;
  assign start      = item_valid && item_ready;

  // The result register is free when empty or being drained this cycle.
  assign res_ready = !result_valid || result_ready;

  olad_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .req       (item),
    .res_ready (res_ready),
    .stat      (stat),
    .res       (res)
  );

  // Output register between the sequencer and the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_ready) begin
      result_valid <= stat.res_valid;
    end
    if (res_ready && stat.res_valid) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire
